/* hw/rtl/smsd_pkg.sv */
package smsd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 8;

    localparam int COUNT_W   = 17;
    localparam int SUM_W     = 32;
    localparam int SQSUM_W   = 47;
    localparam int MEAN_W    = 24;
    localparam int STD_W     = 24;
    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int MEAN_SQ_W = 2 * MEAN_W;

    localparam int DIV_W     = SQSUM_W + 2 * FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int ROOT_W    = (DIV_W + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << COUNT_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          set_last;
    } sample_item_t;

    typedef struct packed {
        logic        [COUNT_W-1:0] sample_count;
        logic signed [SUM_W-1:0]   total_sum;
        logic signed [MEAN_W-1:0]  mean_q8;
        logic        [STD_W-1:0]   std_dev_q8;
        logic                      overflow_flag;
    } result_item_t;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_MEAN_START,
        S_DIV_MEAN,
        S_MSQ_START,
        S_DIV_MSQ,
        S_ROOT_START,
        S_ROOT,
        S_REPORT
    } smsd_state_t;

    typedef struct packed {
        logic take;
        logic mean_start;
        logic msq_start;
        logic mean_capture;
        logic var_capture;
        logic root_start;
        logic result_load;
    } smsd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic root_done;
        logic out_free;
    } smsd_status_t;

endpackage

/* hw/rtl/smsd_stream_if.sv */
interface smsd_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/sum_mean_stddev_engine_top.sv */
// Running mean and standard deviation of signed 16-bit samples. Samples are taken one
// per clock while a set is being collected; each adds to a count, a sum and a sum of
// squares, and samples past 65536 in one set are dropped and flagged. The item marked
// last closes the set: the block then takes no samples while one shared restoring
// divider (one quotient bit per cycle) forms the Q8 mean and the Q16 mean of squares in
// turn, and a bit-pair root unit takes the square root of the variance. The result sits
// in an output register, so the next set can start before it is taken; a further report
// waits until it has been.
module sum_mean_stddev_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    smsd_stream_if.sink   samples,
    smsd_stream_if.source results
);

    smsd_pkg::smsd_cmd_t    cmd;
    smsd_pkg::smsd_status_t status;
    smsd_pkg::sample_item_t sample;
    smsd_pkg::result_item_t result;
    logic                   in_ready;
    logic                   result_valid;

    assign sample = samples.data;

    smsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_last  (sample.set_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    smsd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (results.ready)
    );

    assign samples.ready = in_ready;
    assign results.valid = result_valid;
    assign results.data  = result;

endmodule

/* hw/rtl/smsd_div.sv */
module smsd_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [smsd_pkg::DIV_W-1:0]           dividend,
    input  logic [smsd_pkg::COUNT_W-1:0]         divisor,
    output logic [smsd_pkg::DIV_W-1:0]           quotient,
    output logic                                 done
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [smsd_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [smsd_pkg::DIV_W-1:0]          quo_reg;
    logic [smsd_pkg::DIV_W-1:0]          quo_next;
    logic [smsd_pkg::COUNT_W-1:0]        rem_reg;
    logic [smsd_pkg::COUNT_W-1:0]        rem_next;
    logic [smsd_pkg::COUNT_W:0]          trial;
    logic [smsd_pkg::COUNT_W:0]          diff;
    logic                                fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial    = {rem_reg, quo_reg[smsd_pkg::DIV_W-1]};
        fits     = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = fits ? diff[smsd_pkg::COUNT_W-1:0] : trial[smsd_pkg::COUNT_W-1:0];
        quo_next = {quo_reg[smsd_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= smsd_pkg::DIV_CNT_W'(smsd_pkg::DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* hw/rtl/smsd_isqrt.sv */
module smsd_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [smsd_pkg::RAD_W-1:0]      radicand,
    output logic [smsd_pkg::ROOT_W-1:0]     root,
    output logic                            done
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [smsd_pkg::ROOT_CNT_W-1:0]     cnt_reg;
    logic [smsd_pkg::RAD_W-1:0]          rad_reg;
    logic [smsd_pkg::ROOT_W-1:0]         root_reg;
    logic [smsd_pkg::ROOT_W-1:0]         root_next;
    logic [smsd_pkg::ROOT_W+1:0]         rem_reg;
    logic [smsd_pkg::ROOT_W+1:0]         rem_next;
    logic [smsd_pkg::ROOT_W+3:0]         trial;
    logic [smsd_pkg::ROOT_W+3:0]         sub;
    logic [smsd_pkg::ROOT_W+3:0]         diff;
    logic                                fits;

    // one root bit per cycle from two radicand bits
    always_comb
    begin
        trial     = {rem_reg, rad_reg[smsd_pkg::RAD_W-1 -: 2]};
        sub       = {2'b00, root_reg, 2'b01};
        fits      = trial >= sub;
        diff      = trial - sub;
        rem_next  = fits ? diff[smsd_pkg::ROOT_W+1:0] : trial[smsd_pkg::ROOT_W+1:0];
        root_next = {root_reg[smsd_pkg::ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= smsd_pkg::ROOT_CNT_W'(smsd_pkg::ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/smsd_datapath.sv */
module smsd_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  smsd_pkg::smsd_cmd_t     cmd,
    output smsd_pkg::smsd_status_t  status,
    input  smsd_pkg::sample_item_t  sample,
    output smsd_pkg::result_item_t  result,
    output logic                    result_valid,
    input  logic                    result_ready
);

    logic [smsd_pkg::COUNT_W-1:0]      count_reg;
    logic [smsd_pkg::COUNT_W-1:0]      count_next;
    logic [smsd_pkg::SUM_W-1:0]        sum_reg;
    logic [smsd_pkg::SUM_W-1:0]        sum_next;
    logic [smsd_pkg::SQSUM_W-1:0]      sqsum_reg;
    logic [smsd_pkg::SQSUM_W-1:0]      sqsum_next;
    logic                              dropped_reg;
    logic                              dropped_next;
    logic [smsd_pkg::SQ_W-1:0]         sq_reg;
    logic                              sq_valid_reg;
    logic                              sq_valid_next;
    logic signed [smsd_pkg::SQ_W-1:0]  product;
    logic [smsd_pkg::SUM_W-1:0]        sample_ext;
    logic                              room;

    logic                              sum_neg;
    logic [smsd_pkg::SUM_W-1:0]        sum_mag;
    logic [smsd_pkg::DIV_W-1:0]        div_dividend;
    logic [smsd_pkg::DIV_W-1:0]        quotient;
    logic                              div_done;
    logic [smsd_pkg::MEAN_W-1:0]       mean_mag_reg;
    logic [smsd_pkg::MEAN_SQ_W-1:0]    mean_sq_reg;
    logic [smsd_pkg::DIV_W-1:0]        mean_sq_ext;
    logic [smsd_pkg::RAD_W-1:0]        radicand_reg;
    logic [smsd_pkg::ROOT_W-1:0]       root;
    logic                              root_done;
    logic [smsd_pkg::MEAN_W-1:0]       mean_signed;

    smsd_pkg::result_item_t            out_reg;
    logic                              out_valid_reg;

    // accumulation, square added in the cycle after the sample
    always_comb
    begin
        room          = count_reg < smsd_pkg::COUNT_LIMIT;
        sample_ext    = {{(smsd_pkg::SUM_W - smsd_pkg::SAMPLE_BITS)
                          {sample.sample_value[smsd_pkg::SAMPLE_BITS-1]}},
                         sample.sample_value};
        product       = sample.sample_value * sample.sample_value;
        count_next    = count_reg;
        sum_next      = sum_reg;
        sqsum_next    = sqsum_reg;
        dropped_next  = dropped_reg;
        sq_valid_next = 1'b0;
        if (sq_valid_reg)
        begin
            sqsum_next = sqsum_reg + smsd_pkg::SQSUM_W'(sq_reg);
        end
        if (cmd.take)
        begin
            if (room)
            begin
                count_next    = count_reg + 1'b1;
                sum_next      = sum_reg + sample_ext;
                sq_valid_next = 1'b1;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        if (cmd.result_load)
        begin
            count_next   = '0;
            sum_next     = '0;
            sqsum_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            sqsum_reg    <= '0;
            dropped_reg  <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            sqsum_reg    <= sqsum_next;
            dropped_reg  <= dropped_next;
            sq_valid_reg <= sq_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sq_reg <= product;
        end
    end

    // shared divider: mean magnitude first, then mean of squares
    assign sum_neg = sum_reg[smsd_pkg::SUM_W-1];
    assign sum_mag = sum_neg ? (~sum_reg + 1'b1) : sum_reg;

    always_comb
    begin
        if (cmd.mean_start)
        begin
            div_dividend = smsd_pkg::DIV_W'(sum_mag) << smsd_pkg::FRAC_BITS;
        end
        else
        begin
            div_dividend = smsd_pkg::DIV_W'(sqsum_reg) << (2 * smsd_pkg::FRAC_BITS);
        end
    end

    smsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mean_start | cmd.msq_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign mean_sq_ext = smsd_pkg::DIV_W'(mean_sq_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mean_capture)
        begin
            mean_mag_reg <= quotient[smsd_pkg::MEAN_W-1:0];
        end
        mean_sq_reg <= mean_mag_reg * mean_mag_reg;
        if (cmd.var_capture)
        begin
            // negative variance clamps to zero
            if (quotient > mean_sq_ext)
            begin
                radicand_reg <= smsd_pkg::RAD_W'(quotient - mean_sq_ext);
            end
            else
            begin
                radicand_reg <= '0;
            end
        end
    end

    smsd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (radicand_reg),
        .root     (root),
        .done     (root_done)
    );

    assign mean_signed = sum_neg ? (~mean_mag_reg + 1'b1) : mean_mag_reg;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_reg.sample_count  <= count_reg;
            out_reg.total_sum     <= sum_reg;
            out_reg.mean_q8       <= mean_signed;
            out_reg.std_dev_q8    <= root[smsd_pkg::STD_W-1:0];
            out_reg.overflow_flag <= dropped_reg;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign status.div_done  = div_done;
    assign status.root_done = root_done;
    assign status.out_free  = !out_valid_reg || result_ready;

endmodule

/* hw/rtl/smsd_ctrl.sv */
module smsd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_last,
    output logic                    in_ready,
    input  smsd_pkg::smsd_status_t  status,
    output smsd_pkg::smsd_cmd_t     cmd
);

    smsd_pkg::smsd_state_t state_reg;
    smsd_pkg::smsd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smsd_pkg::S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            smsd_pkg::S_COLLECT:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = smsd_pkg::S_MEAN_START;
                end
            end
            smsd_pkg::S_MEAN_START:
            begin
                cmd.mean_start = 1'b1;
                state_next     = smsd_pkg::S_DIV_MEAN;
            end
            smsd_pkg::S_DIV_MEAN:
            begin
                if (status.div_done)
                begin
                    cmd.mean_capture = 1'b1;
                    state_next       = smsd_pkg::S_MSQ_START;
                end
            end
            smsd_pkg::S_MSQ_START:
            begin
                cmd.msq_start = 1'b1;
                state_next    = smsd_pkg::S_DIV_MSQ;
            end
            smsd_pkg::S_DIV_MSQ:
            begin
                if (status.div_done)
                begin
                    cmd.var_capture = 1'b1;
                    state_next      = smsd_pkg::S_ROOT_START;
                end
            end
            smsd_pkg::S_ROOT_START:
            begin
                cmd.root_start = 1'b1;
                state_next     = smsd_pkg::S_ROOT;
            end
            smsd_pkg::S_ROOT:
            begin
                if (status.root_done)
                begin
                    state_next = smsd_pkg::S_REPORT;
                end
            end
            smsd_pkg::S_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = smsd_pkg::S_COLLECT;
                end
            end
            default:
            begin
                state_next = smsd_pkg::S_COLLECT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == smsd_pkg::S_DIV_MEAN ||
                             state_reg == smsd_pkg::S_DIV_MSQ))
        else $error("divider finished outside a divide wait");

    a_root_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.root_done |-> state_reg == smsd_pkg::S_ROOT)
        else $error("root unit finished outside the root wait");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_last_starts_report: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && in_last) |=> (state_reg == smsd_pkg::S_MEAN_START && !in_ready))
        else $error("last item did not start the set report");
`endif

endmodule

/* tb/tb_sum_mean_stddev_engine_top.sv */
`timescale 1ns / 100ps

module tb_sum_mean_stddev_engine_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_GAP     = 18;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_CYCLES = 3000;
    localparam int SHOW_LIMIT  = 10;
    localparam int RANDOM_ITEMS = 1200;

    localparam logic signed [smsd_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [smsd_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    class stats_checker;
        logic [smsd_pkg::COUNT_W-1:0] run_count;
        logic [smsd_pkg::SUM_W-1:0]   run_sum;
        logic [smsd_pkg::SQSUM_W-1:0] run_sq;
        bit                           dropped;
        smsd_pkg::result_item_t       pending_reports[$];
        int                           errors;
        int                           shown;

        function new();
            restart_set();
            errors = 0;
            shown  = 0;
        endfunction

        function void restart_set();
            run_count = '0;
            run_sum   = '0;
            run_sq    = '0;
            dropped   = 1'b0;
        endfunction

        // accumulate one sample and, on the last of a set, predict its report
        function void note_sample(logic signed [smsd_pkg::SAMPLE_BITS-1:0] value, bit last);
            logic signed [63:0]     wide;
            longint                 total;
            longint                 mean;
            logic [63:0]            cnt64;
            logic [63:0]            msq;
            logic [63:0]            msq2;
            logic [63:0]            amean;
            logic [63:0]            spread;
            logic [63:0]            root;
            logic [63:0]            trial;
            smsd_pkg::result_item_t r;
            wide = value;
            if (run_count < smsd_pkg::COUNT_LIMIT)
            begin
                run_count = run_count + 1'b1;
                run_sum   = run_sum + wide[smsd_pkg::SUM_W-1:0];
                run_sq    = run_sq + smsd_pkg::SQSUM_W'(wide * wide);
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!last)
                return;
            cnt64  = run_count;
            total  = $signed(run_sum);
            mean   = (total * (longint'(1) << smsd_pkg::FRAC_BITS)) / longint'(cnt64);
            msq    = ({17'b0, run_sq} << (2 * smsd_pkg::FRAC_BITS)) / cnt64;
            amean  = (mean < 0) ? -mean : mean;
            msq2   = amean * amean;
            spread = (msq > msq2) ? msq - msq2 : 64'd0;
            root   = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= spread)
                    root = trial;
            end
            r.sample_count  = run_count;
            r.total_sum     = run_sum;
            r.mean_q8       = mean[smsd_pkg::MEAN_W-1:0];
            r.std_dev_q8    = root[smsd_pkg::STD_W-1:0];
            r.overflow_flag = dropped;
            pending_reports = {pending_reports, r};
            restart_set();
        endfunction

        function void check_result(smsd_pkg::result_item_t got);
            smsd_pkg::result_item_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    $display("unexpected report: count %0d sum %0d mean %0d std %0d ovf %0b",
                             got.sample_count, got.total_sum, got.mean_q8, got.std_dev_q8,
                             got.overflow_flag);
                    shown++;
                end
                return;
            end
            want = pending_reports.pop_front();
            if (got.sample_count !== want.sample_count || got.total_sum !== want.total_sum ||
                got.mean_q8 !== want.mean_q8 || got.std_dev_q8 !== want.std_dev_q8 ||
                got.overflow_flag !== want.overflow_flag)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    $display("report mismatch at %0t", $realtime);
                    $display("  expected: count %0d sum %0d mean %0d std %0d ovf %0b",
                             want.sample_count, want.total_sum, want.mean_q8,
                             want.std_dev_q8, want.overflow_flag);
                    $display("  actual:   count %0d sum %0d mean %0d std %0d ovf %0b",
                             got.sample_count, got.total_sum, got.mean_q8,
                             got.std_dev_q8, got.overflow_flag);
                    shown++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    smsd_stream_if #(.data_t(smsd_pkg::sample_item_t)) sample_bus ();
    smsd_stream_if #(.data_t(smsd_pkg::result_item_t)) report_bus ();

    stats_checker set_stats = new();

    bit hold_results = 1'b0;
    bit random_phase = 1'b0;
    int src_run = 0;
    bit src_calm = 1'b0;
    int snk_run = 0;
    bit snk_calm = 1'b0;
    int cycle_count = 0;

    sum_mean_stddev_engine_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (report_bus)
    );

    always #5 clk = ~clk;

    // stretches of random gaps are mixed with stretches of none
    function automatic int draw_gap(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            calm     = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_sample(input logic signed [smsd_pkg::SAMPLE_BITS-1:0] value,
                               input bit last, input bit rush);
        int                     gap;
        smsd_pkg::sample_item_t item;
        gap = rush ? 0 : draw_gap(src_run, src_calm);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.sample_value = value;
        item.set_last     = last;
        sample_bus.valid <= 1'b1;
        sample_bus.data  <= item;
        do @(posedge clk); while (!sample_bus.ready);
        set_stats.note_sample(value, last);
    endtask

    task automatic drain_results();
        int gap;
        forever
        begin
            gap = draw_gap(snk_run, snk_calm);
            if (gap > 0 || hold_results)
            begin
                report_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_results) @(posedge clk);
            end
            report_bus.ready <= 1'b1;
            do @(posedge clk); while (!report_bus.valid);
            set_stats.check_result(report_bus.data);
        end
    endtask

    task automatic finish_run(input bit clean);
        if (clean)
            $display("sum_mean_stddev_engine_top verification clean");
        else
            $display("sum_mean_stddev_engine_top verification failed");
        $finish;
    endtask

    function automatic logic signed [smsd_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return smsd_pkg::SAMPLE_BITS'($urandom_range(0, 64)) - 16'sd32;
            default: return smsd_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        sample_bus.valid = 1'b0;
        sample_bus.data  = '0;
        report_bus.ready = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        drain_results();
    end

    // long hold-off on the report side so the block backs up and stalls its input
    initial
    begin
        wait (random_phase);
        repeat (300) @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        finish_run(1'b0);
    end

    initial
    begin
        int                                      sent;
        int                                      len;
        bit                                      flat;
        logic signed [smsd_pkg::SAMPLE_BITS-1:0] flat_value;
        logic signed [smsd_pkg::SAMPLE_BITS-1:0] v;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // single-sample sets at the extremes and zero
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1, 1'b0);
        send_sample(16'sd0, 1'b1, 1'b0);
        // negative mean truncated toward zero
        send_sample(-16'sd1, 1'b0, 1'b0);
        send_sample(16'sd0, 1'b0, 1'b0);
        send_sample(16'sd0, 1'b1, 1'b0);
        // positive fractional mean
        send_sample(16'sd1, 1'b0, 1'b0);
        send_sample(16'sd1, 1'b0, 1'b0);
        send_sample(16'sd2, 1'b1, 1'b0);
        // widest spread
        send_sample(SAMPLE_MAX, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1, 1'b0);
        // constant set, zero variance
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1, 1'b0);
        send_sample(16'sd5, 1'b0, 1'b0);
        send_sample(-16'sd7, 1'b0, 1'b0);
        send_sample(16'sd100, 1'b0, 1'b0);
        send_sample(-16'sd3000, 1'b0, 1'b0);
        send_sample(16'sd12345, 1'b1, 1'b0);

        random_phase = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                               : $urandom_range(1, 12);
            flat = ($urandom_range(0, 5) == 0);
            flat_value = pick_sample();
            for (int i = 0; i < len; i++)
            begin
                v = flat ? flat_value : pick_sample();
                send_sample(v, i == len - 1, 1'b0);
            end
            sent += len;
        end
        sample_bus.valid <= 1'b0;

        while (set_stats.pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        set_stats.errors += set_stats.pending_reports.size();
        finish_run(set_stats.errors == 0);
    end

endmodule
